[sv/ilp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ilp_pkg
// Shared types and constants of the integer literal parser: channel payloads,
// the classified character that travels through the queue, and scan codes.
// ============================================================================
package ilp_pkg;

   localparam int ILP_VALUE_BITS  = 64;
   localparam int ILP_QUEUE_DEPTH = 4;

   // Character codes recognized by the lexer
   localparam logic [20:0] CHAR_QUOTE   = 21'h27;
   localparam logic [20:0] CHAR_ZERO    = 21'h30;
   localparam logic [20:0] CHAR_ONE     = 21'h31;
   localparam logic [20:0] CHAR_NINE    = 21'h39;
   localparam logic [20:0] CHAR_UP_A    = 21'h41;
   localparam logic [20:0] CHAR_UP_F    = 21'h46;
   localparam logic [20:0] CHAR_LO_A    = 21'h61;
   localparam logic [20:0] CHAR_LO_F    = 21'h66;
   localparam logic [20:0] CHAR_UP_B    = 21'h42;
   localparam logic [20:0] CHAR_LO_B    = 21'h62;
   localparam logic [20:0] CHAR_UP_X    = 21'h58;
   localparam logic [20:0] CHAR_LO_X    = 21'h78;
   localparam logic [20:0] CHAR_UP_U    = 21'h55;
   localparam logic [20:0] CHAR_LO_U    = 21'h75;
   localparam logic [20:0] CHAR_UP_L    = 21'h4C;
   localparam logic [20:0] CHAR_LO_L    = 21'h6C;
   localparam logic [20:0] CHAR_UP_Z    = 21'h5A;
   localparam logic [20:0] CHAR_LO_Z    = 21'h7A;
   localparam logic [3:0]  HEX_LETTER_OFFSET = 4'd9;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_ZERO   = 4'd1,
      PH_DIGITS = 4'd2,
      PH_SUF_U  = 4'd3,
      PH_SUF_L  = 4'd4,
      PH_SUF_L2 = 4'd5,
      PH_SUF_LU = 4'd6,
      PH_SUF_Z  = 4'd7,
      PH_SUF_ZU = 4'd8,
      PH_DONE   = 4'd9,
      PH_JUNK   = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_BIN = 2'd1,
      BASE_OCT = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LEAD_SEP = 2'd1,
      STATUS_TRAIL_SEP = 2'd2,
      STATUS_TRAILING = 2'd3
   } status_type;

   typedef struct packed {
      logic [20:0] char_code;
      logic        last_of_token;
   } req_type;

   typedef struct packed {
      logic [63:0] literal_value;
      logic [1:0]  number_base;
      logic        suffix_unsigned;
      logic        suffix_long;
      logic        suffix_long_long;
      logic        suffix_size;
      logic [1:0]  parse_status;
   } rsp_type;

   // One character after classification
   typedef struct packed {
      logic       last;
      logic       is_zero;
      logic       is_dec_lead;   // 1..9
      logic       is_quote;
      logic       is_b;
      logic       is_x;
      logic       is_u;
      logic       is_l;
      logic       is_z;
      logic       is_hex;        // any hex digit
      logic [3:0] digit;
   } char_class_type;

endpackage

[sv/ilp_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// ilp_front
// Input stage: registers each incoming character and classifies it into
// digit / prefix / suffix / separator flags before it enters the queue.
// ============================================================================
module ilp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ilp_pkg::req_type        req_payload,
   output logic                    push,
   output ilp_pkg::char_class_type push_item,
   input  logic                    queue_full
);
   import ilp_pkg::*;

   logic           front_valid_ff;
   char_class_type front_item_ff;
   char_class_type class_in;
   logic [20:0]    cc;

   always_comb begin
      cc = req_payload.char_code;
      class_in.last        = req_payload.last_of_token;
      class_in.is_zero     = (cc == CHAR_ZERO);
      class_in.is_dec_lead = (cc >= CHAR_ONE) && (cc <= CHAR_NINE);
      class_in.is_quote    = (cc == CHAR_QUOTE);
      class_in.is_b        = (cc == CHAR_LO_B) || (cc == CHAR_UP_B);
      class_in.is_x        = (cc == CHAR_LO_X) || (cc == CHAR_UP_X);
      class_in.is_u        = (cc == CHAR_LO_U) || (cc == CHAR_UP_U);
      class_in.is_l        = (cc == CHAR_LO_L) || (cc == CHAR_UP_L);
      class_in.is_z        = (cc == CHAR_LO_Z) || (cc == CHAR_UP_Z);
      if ((cc >= CHAR_ZERO) && (cc <= CHAR_NINE)) begin
         class_in.is_hex = 1'b1;
         class_in.digit  = cc[3:0];
      end else if (((cc >= CHAR_LO_A) && (cc <= CHAR_LO_F)) ||
                   ((cc >= CHAR_UP_A) && (cc <= CHAR_UP_F))) begin
         class_in.is_hex = 1'b1;
         class_in.digit  = cc[3:0] + HEX_LETTER_OFFSET;
      end else begin
         class_in.is_hex = 1'b0;
         class_in.digit  = 4'd0;
      end
   end

   assign push      = front_valid_ff && !queue_full;
   assign push_item = front_item_ff;
   assign req_stall = front_valid_ff && queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         front_item_ff <= class_in;
      end
   end

endmodule

[sv/ilp_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// ilp_queue
// Short FIFO of classified characters between the front and the back.
// ============================================================================
module ilp_queue #(
   parameter int DEPTH = ilp_pkg::ILP_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ilp_pkg::char_class_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output ilp_pkg::char_class_type pop_item
);
   import ilp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   char_class_type     entries [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_empty_ptrs_equal : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers differ");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue popped while empty");

endmodule

[sv/ilp_exec.sv]
`timescale 1ns / 1ps
// ============================================================================
// ilp_exec
// Back end: scan state machine, base detection, value accumulation, suffix
// grammar and the registered result stage.
// ============================================================================
module ilp_exec #(
   parameter int VALUE_BITS = ilp_pkg::ILP_VALUE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  ilp_pkg::char_class_type item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ilp_pkg::rsp_type        rsp_payload
);
   import ilp_pkg::*;

   typedef struct packed {
      logic u;
      logic l;
      logic ll;
      logic z;
   } sfx_type;

   typedef struct packed {
      phase_type phase;
      sfx_type   flags;
      logic      garbage;
   } sfx_step_type;

   // Suffix grammar: a phase that does not take the character hands it on.
   function automatic sfx_step_type suffix_step(phase_type ph, sfx_type f,
                                                char_class_type c);
      sfx_step_type r;
      logic         busy;
      r.phase   = ph;
      r.flags   = f;
      r.garbage = 1'b0;
      busy      = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (busy) begin
            case (r.phase)
               PH_SUF_U: begin
                  if (c.is_u) begin
                     r.flags.u = 1'b1;
                     busy = 1'b0;
                  end
                  r.phase = PH_SUF_L;
               end
               PH_SUF_L: begin
                  if (c.is_l) begin
                     r.flags.l = 1'b1;
                     r.phase = PH_SUF_L2;
                     busy = 1'b0;
                  end else begin
                     r.phase = PH_SUF_Z;
                  end
               end
               PH_SUF_L2: begin
                  if (c.is_l) begin
                     r.flags.l  = 1'b0;
                     r.flags.ll = 1'b1;
                     busy = 1'b0;
                  end
                  r.phase = PH_SUF_LU;
               end
               PH_SUF_LU: begin
                  if (c.is_u) begin
                     r.flags.u = 1'b1;
                     busy = 1'b0;
                  end
                  r.phase = PH_SUF_Z;
               end
               PH_SUF_Z: begin
                  if (c.is_z && !r.flags.l && !r.flags.ll) begin
                     r.flags.z = 1'b1;
                     r.phase = PH_SUF_ZU;
                  end else begin
                     r.phase   = PH_JUNK;
                     r.garbage = 1'b1;
                  end
                  busy = 1'b0;
               end
               PH_SUF_ZU: begin
                  if (c.is_u) begin
                     r.flags.u = 1'b1;
                     r.phase = PH_DONE;
                  end else begin
                     r.phase   = PH_JUNK;
                     r.garbage = 1'b1;
                  end
                  busy = 1'b0;
               end
               default: begin
                  r.phase   = PH_JUNK;
                  r.garbage = 1'b1;
                  busy = 1'b0;
               end
            endcase
         end
      end
      return r;
   endfunction

   function automatic logic digit_ok(base_type b, char_class_type c);
      logic ok;
      case (b)
         BASE_BIN: ok = c.is_hex && (c.digit <= 4'd1);
         BASE_OCT: ok = c.is_hex && (c.digit <= 4'd7);
         BASE_DEC: ok = c.is_hex && (c.digit <= 4'd9);
         default:  ok = c.is_hex;
      endcase
      return ok;
   endfunction

   // acc * radix as shifts, plus one add for decimal
   function automatic logic [VALUE_BITS-1:0] radix_mul(logic [VALUE_BITS-1:0] a,
                                                      base_type b);
      logic [VALUE_BITS-1:0] p;
      case (b)
         BASE_BIN: p = a << 1;
         BASE_OCT: p = a << 3;
         BASE_HEX: p = a << 4;
         default:  p = (a << 3) + (a << 1);
      endcase
      return p;
   endfunction

   phase_type             phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   base_type              base_ff, base_in;
   sfx_type               sfx_ff, sfx_in;
   logic                  dsf_ff, dsf_in;
   logic                  lq_ff, lq_in;
   logic                  tq_ff, tq_in;
   logic                  garb_ff, garb_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  run;
   base_type              run_base;
   logic                  suffix_go;
   phase_type             suffix_start;
   sfx_step_type          sfx_res;
   logic                  advance;

   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall || !item.last);
   assign pop     = advance;

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      sfx_in       = sfx_ff;
      dsf_in       = dsf_ff;
      lq_in        = lq_ff;
      tq_in        = tq_ff;
      garb_in      = garb_ff;
      run          = 1'b0;
      run_base     = base_ff;
      suffix_go    = 1'b0;
      suffix_start = phase_ff;
      sfx_res      = '0;

      case (phase_ff)
         PH_START: begin
            if (item.is_zero) begin
               phase_in = PH_ZERO;
            end else if (item.is_dec_lead) begin
               base_in  = BASE_DEC;
               dsf_in   = 1'b0;
               acc_in   = VALUE_BITS'(item.digit);
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_JUNK;
               garb_in  = 1'b1;
            end
         end
         PH_ZERO: begin
            if (item.is_b) begin
               base_in  = BASE_BIN;
               phase_in = PH_DIGITS;
            end else if (item.is_x) begin
               base_in  = BASE_HEX;
               phase_in = PH_DIGITS;
            end else begin
               // the character after the leading zero starts an octal run
               base_in  = BASE_OCT;
               if (item.is_quote) begin
                  lq_in = 1'b1;
               end
               dsf_in   = 1'b0;
               phase_in = PH_DIGITS;
               run      = 1'b1;
               run_base = BASE_OCT;
            end
         end
         PH_DIGITS: begin
            run = 1'b1;
         end
         PH_JUNK: begin
         end
         PH_DONE: begin
            phase_in = PH_JUNK;
            garb_in  = 1'b1;
         end
         default: begin
            suffix_go = 1'b1;
         end
      endcase

      if (run) begin
         if (item.is_quote) begin
            if (dsf_in) begin
               lq_in = 1'b1;
            end
            dsf_in = 1'b0;
            tq_in  = 1'b1;
         end else if (digit_ok(run_base, item)) begin
            dsf_in = 1'b0;
            acc_in = radix_mul(acc_ff, run_base) + VALUE_BITS'(item.digit);
            tq_in  = 1'b0;
         end else begin
            suffix_go    = 1'b1;
            suffix_start = PH_SUF_U;
         end
      end

      if (suffix_go) begin
         sfx_res  = suffix_step(suffix_start, sfx_ff, item);
         phase_in = sfx_res.phase;
         sfx_in   = sfx_res.flags;
         garb_in  = garb_in | sfx_res.garbage;
      end

      rsp_in.literal_value    = 64'(acc_in);
      rsp_in.number_base      = (phase_in == PH_ZERO) ? BASE_OCT : base_in;
      rsp_in.suffix_unsigned  = sfx_in.u;
      rsp_in.suffix_long      = sfx_in.l;
      rsp_in.suffix_long_long = sfx_in.ll;
      rsp_in.suffix_size      = sfx_in.z;
      if (lq_in) begin
         rsp_in.parse_status = STATUS_LEAD_SEP;
      end else if (tq_in) begin
         rsp_in.parse_status = STATUS_TRAIL_SEP;
      end else if (garb_in) begin
         rsp_in.parse_status = STATUS_TRAILING;
      end else begin
         rsp_in.parse_status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last)) begin
         phase_ff <= PH_START;
         acc_ff   <= '0;
         base_ff  <= BASE_DEC;
         sfx_ff   <= '0;
         dsf_ff   <= 1'b1;
         lq_ff    <= 1'b0;
         tq_ff    <= 1'b0;
         garb_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         sfx_ff   <= sfx_in;
         dsf_ff   <= dsf_in;
         lq_ff    <= lq_in;
         tq_ff    <= tq_in;
         garb_ff  <= garb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && item.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_token_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (advance && item.last) |=> (phase_ff == PH_START) && (acc_ff == '0))
      else $error("scan state not cleared after token end");

   a_long_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(sfx_ff.l && sfx_ff.ll))
      else $error("l and ll suffix flags both set");

endmodule

[sv/integer_literal_parser_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// integer_literal_parser_core
// Integer literal lexer: characters in, parsed value, base, suffix, status out.
// ============================================================================
// Usage:
//   req_* carries one token character per transaction (code point plus a
//   last-of-token mark). rsp_* carries one result transaction per token,
//   produced by the character marked last: value modulo 2^VALUE_BITS
//   (zero-extended to 64 bits), base, u/l/ll/z flags and parse status.
//   Both channels transfer when valid is high and stall is low.
//
//   Path: the last character's result reaches rsp_valid through the front
//   register, the queue write and then the result register when the queue
//   is empty. Throughput is one character per cycle while req_stall is low
//   and no held result stops a last character; the scan state machine and
//   its shift-and-add accumulator update once per character.
//
//   A stalled result is held in the output register while the back end keeps
//   consuming characters of the next token; only the next last character
//   waits. Once the queue fills (QUEUE_DEPTH entries) req_stall rises.
//
//   Reset (synchronous, active high) empties the queue, drops any pending
//   result and returns the scanner to token start.
// ============================================================================
module integer_literal_parser_core #(
   parameter int VALUE_BITS  = ilp_pkg::ILP_VALUE_BITS,
   parameter int QUEUE_DEPTH = ilp_pkg::ILP_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ilp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ilp_pkg::rsp_type rsp_payload
);
   import ilp_pkg::*;

   // front -> queue
   logic           push;
   char_class_type push_item;
   logic           queue_full;
   // queue -> back end
   logic           pop;
   logic           pop_valid;
   char_class_type pop_item;

   // Front: register and classify each incoming character
   ilp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   // Decoupling queue
   ilp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // Back end: scanner, accumulator and result register
   ilp_exec #(
      .VALUE_BITS (VALUE_BITS)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (pop_valid),
      .item        (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[verif/tb_integer_literal_parser_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_integer_literal_parser_core
// Self-checking bench for the integer literal lexer core.
// ----------------------------------------------------------------------------
// Characters are fed one per transaction. A scoreboard-side copy of the lexer
// predicts every token result when the last character is accepted; the
// checker compares each result transaction field by field, in order. Named
// tests cover the base prefixes, separators, suffixes and wide code points,
// then random tokens with random idling on both channels, a long result
// hold-off that fills the core, and a gap-free tail.
// ============================================================================
module tb_integer_literal_parser_core;
   import ilp_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 10;
   localparam int MAX_PRINTS    = 40;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Suffix strings: the suffix grammar's accepted forms and a few broken ones
   string suffix_forms[22] = '{"", "u", "U", "l", "L", "ll", "LL", "ul", "Ul", "lu",
                               "uLL", "llU", "z", "Z", "zu", "uz", "Zu", "lz", "uu",
                               "lL", "zz", "ullz"};

   // Bench control
   bit idle_enabled    = 1'b1;   // random gaps on the request side, stalls on rsp
   bit long_hold_armed = 1'b0;   // asks the stall driver for one long hold-off
   int hold_count      = 0;
   int burst_count     = 0;
   int cycle_count     = 0;
   int error_count     = 0;
   int chars_sent      = 0;

   // Token results still owed by the core, oldest first
   rsp_type expected_literals[$];

   // Shadow lexer state
   phase_type   lex_phase;
   logic [63:0] lex_value;
   base_type    lex_base;
   logic        sfx_u, sfx_l, sfx_ll, sfx_z;
   logic        no_digit_yet;
   logic        lead_sep_seen;
   logic        trail_sep_pending;
   logic        junk_seen;

   integer_literal_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow lexer
   // ---------------------------------------------------------------------
   function automatic void clear_lexer();
      lex_phase         = PH_START;
      lex_value         = '0;
      lex_base          = BASE_DEC;
      sfx_u             = 1'b0;
      sfx_l             = 1'b0;
      sfx_ll            = 1'b0;
      sfx_z             = 1'b0;
      no_digit_yet      = 1'b1;
      lead_sep_seen     = 1'b0;
      trail_sep_pending = 1'b0;
      junk_seen         = 1'b0;
   endfunction

   function automatic bit is_u(logic [20:0] c);
      return c == CHAR_LO_U || c == CHAR_UP_U;
   endfunction

   function automatic bit is_l(logic [20:0] c);
      return c == CHAR_LO_L || c == CHAR_UP_L;
   endfunction

   function automatic bit is_z(logic [20:0] c);
      return c == CHAR_LO_Z || c == CHAR_UP_Z;
   endfunction

   // Digit value in the current base, -1 when c is not a digit of it
   function automatic int digit_value(logic [20:0] c);
      int d;
      d = -1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) d = int'(c - CHAR_ZERO);
      else if (c >= CHAR_LO_A && c <= CHAR_LO_F) d = 10 + int'(c - CHAR_LO_A);
      else if (c >= CHAR_UP_A && c <= CHAR_UP_F) d = 10 + int'(c - CHAR_UP_A);
      case (lex_base)
         BASE_BIN: if (d > 1) d = -1;
         BASE_OCT: if (d > 7) d = -1;
         BASE_DEC: if (d > 9) d = -1;
         default: ;
      endcase
      return d;
   endfunction

   function automatic logic [63:0] radix_of(base_type b);
      case (b)
         BASE_BIN: return 64'd2;
         BASE_OCT: return 64'd8;
         BASE_HEX: return 64'd16;
         default:  return 64'd10;
      endcase
   endfunction

   // Suffix grammar: a phase that does not take c passes it on to the next one
   function automatic void lex_suffix(logic [20:0] c);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         taken = 1'b1;
         case (lex_phase)
            PH_SUF_U: begin
               if (is_u(c)) sfx_u = 1'b1;
               else taken = 1'b0;
               lex_phase = PH_SUF_L;
            end
            PH_SUF_L: begin
               if (is_l(c)) begin
                  sfx_l = 1'b1;
                  lex_phase = PH_SUF_L2;
               end else begin
                  taken = 1'b0;
                  lex_phase = PH_SUF_Z;
               end
            end
            PH_SUF_L2: begin
               if (is_l(c)) begin
                  sfx_l  = 1'b0;
                  sfx_ll = 1'b1;
               end else begin
                  taken = 1'b0;
               end
               lex_phase = PH_SUF_LU;
            end
            PH_SUF_LU: begin
               if (is_u(c)) sfx_u = 1'b1;
               else taken = 1'b0;
               lex_phase = PH_SUF_Z;
            end
            PH_SUF_Z: begin
               // z never combines with l or ll
               if (is_z(c) && !sfx_l && !sfx_ll) begin
                  sfx_z = 1'b1;
                  lex_phase = PH_SUF_ZU;
               end else begin
                  lex_phase = PH_JUNK;
                  junk_seen = 1'b1;
               end
            end
            PH_SUF_ZU: begin
               if (is_u(c)) begin
                  sfx_u = 1'b1;
                  lex_phase = PH_DONE;
               end else begin
                  lex_phase = PH_JUNK;
                  junk_seen = 1'b1;
               end
            end
            default: begin
               lex_phase = PH_JUNK;
               junk_seen = 1'b1;
            end
         endcase
      end
   endfunction

   function automatic void lex_digit_run(logic [20:0] c);
      int d;
      if (c == CHAR_QUOTE) begin
         if (no_digit_yet) lead_sep_seen = 1'b1;
         no_digit_yet      = 1'b0;
         trail_sep_pending = 1'b1;
         return;
      end
      d = digit_value(c);
      if (d >= 0) begin
         no_digit_yet      = 1'b0;
         lex_value         = lex_value * radix_of(lex_base) + 64'(d);
         trail_sep_pending = 1'b0;
         return;
      end
      lex_phase = PH_SUF_U;
      lex_suffix(c);
   endfunction

   function automatic void lex_char(logic [20:0] c);
      case (lex_phase)
         PH_START: begin
            if (c == CHAR_ZERO) begin
               lex_phase = PH_ZERO;
            end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
               lex_base     = BASE_DEC;
               no_digit_yet = 1'b0;
               lex_value    = 64'(c - CHAR_ZERO);
               lex_phase    = PH_DIGITS;
            end else begin
               lex_phase = PH_JUNK;
               junk_seen = 1'b1;
            end
         end
         PH_ZERO: begin
            if (c == CHAR_LO_B || c == CHAR_UP_B) begin
               lex_base  = BASE_BIN;
               lex_phase = PH_DIGITS;
            end else if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               lex_base  = BASE_HEX;
               lex_phase = PH_DIGITS;
            end else begin
               // quote right after the octal zero counts as a leading separator
               lex_base = BASE_OCT;
               if (c == CHAR_QUOTE) lead_sep_seen = 1'b1;
               no_digit_yet = 1'b0;
               lex_phase    = PH_DIGITS;
               lex_digit_run(c);
            end
         end
         PH_DIGITS: lex_digit_run(c);
         PH_JUNK: ;
         PH_DONE: begin
            lex_phase = PH_JUNK;
            junk_seen = 1'b1;
         end
         default: lex_suffix(c);
      endcase
   endfunction

   // Called once per accepted character transaction
   function automatic void predict_char(logic [20:0] c, logic is_last);
      rsp_type    r;
      status_type st;
      lex_char(c);
      if (!is_last) return;
      // bare "0" ends in the zero phase and is plain octal zero
      if (lex_phase == PH_ZERO) lex_base = BASE_OCT;
      if (lead_sep_seen) st = STATUS_LEAD_SEP;
      else if (trail_sep_pending) st = STATUS_TRAIL_SEP;
      else if (junk_seen) st = STATUS_TRAILING;
      else st = STATUS_OK;
      r.literal_value    = lex_value;
      r.number_base      = lex_base;
      r.suffix_unsigned  = sfx_u;
      r.suffix_long      = sfx_l;
      r.suffix_long_long = sfx_ll;
      r.suffix_size      = sfx_z;
      r.parse_status     = st;
      expected_literals.push_back(r);
      clear_lexer();
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one character and returns at the edge that accepts it.
   task automatic send_char(input logic [20:0] code, input logic is_last);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{char_code: code, last_of_token: is_last};
      do @(posedge clock); while (req_stall);
      predict_char(code, is_last);
      chars_sent++;
   endtask

   task automatic send_token(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char({13'd0, s[i]}, i == s.len() - 1);
   endtask

   function automatic logic [20:0] digit_char(int d, bit upper);
      if (d < 10) return CHAR_ZERO + 21'(d);
      return (upper ? CHAR_UP_A : CHAR_LO_A) + 21'(d - 10);
   endfunction

   // Mostly well-formed literals with random digits, separators and suffix;
   // about one in five gets a stray character somewhere.
   task automatic send_random_token();
      logic [20:0] tok[$];
      logic [20:0] stray;
      int          radix_n;
      int          ndig;
      string       sfx;
      radix_n = 10;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: tok.push_back(CHAR_ONE + 21'($urandom_range(0, 8)));
         4, 9: begin
            tok.push_back(CHAR_ZERO);
            tok.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
            radix_n = 16;
         end
         5: begin
            tok.push_back(CHAR_ZERO);
            tok.push_back($urandom_range(0, 1) ? CHAR_LO_B : CHAR_UP_B);
            radix_n = 2;
         end
         6, 7: begin
            tok.push_back(CHAR_ZERO);
            radix_n = 8;
         end
         default: begin
            tok.push_back(CHAR_ZERO);   // bare zero, maybe with a suffix
            radix_n = 0;
         end
      endcase
      // long runs now and then so the accumulator wraps
      ndig = ($urandom_range(0, 12) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 5);
      if (radix_n == 0) ndig = 0;
      for (int i = 0; i < ndig; i++) begin
         if ($urandom_range(0, 7) == 0) tok.push_back(CHAR_QUOTE);
         tok.push_back(digit_char($urandom_range(0, radix_n - 1),
                                  1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 11) == 0) tok.push_back(CHAR_QUOTE);
      sfx = ($urandom_range(0, 2) == 0) ? "" : suffix_forms[$urandom_range(0, 21)];
      for (int i = 0; i < sfx.len(); i++) tok.push_back({13'd0, sfx[i]});
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0:       stray = 21'($urandom_range(0, 21'h1F_FFFF));
            1:       stray = 21'($urandom_range(32, 126));
            2:       stray = CHAR_QUOTE;
            default: stray = digit_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
         endcase
         tok.insert($urandom_range(0, tok.size()), stray);
      end
      for (int i = 0; i < tok.size(); i++) send_char(tok[i], i == tok.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   // Stall driver: random short stall bursts, or one long hold-off on request.
   always @(posedge clock) begin : rsp_stall_driver
      if (long_hold_armed) begin
         long_hold_armed = 1'b0;
         hold_count      = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else if (burst_count > 0) begin
         burst_count--;
         rsp_stall <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
         burst_count = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_PRINTS)
         $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Every accepted result transaction is checked against the oldest prediction
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_literals.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.literal_value, '0);
         end else begin
            want = expected_literals.pop_front();
            if (rsp_payload.literal_value !== want.literal_value)
               report_mismatch("literal_value", rsp_payload.literal_value,
                               want.literal_value);
            if (rsp_payload.number_base !== want.number_base)
               report_mismatch("number_base", 64'(rsp_payload.number_base),
                               64'(want.number_base));
            if (rsp_payload.suffix_unsigned !== want.suffix_unsigned)
               report_mismatch("suffix_unsigned", 64'(rsp_payload.suffix_unsigned),
                               64'(want.suffix_unsigned));
            if (rsp_payload.suffix_long !== want.suffix_long)
               report_mismatch("suffix_long", 64'(rsp_payload.suffix_long),
                               64'(want.suffix_long));
            if (rsp_payload.suffix_long_long !== want.suffix_long_long)
               report_mismatch("suffix_long_long", 64'(rsp_payload.suffix_long_long),
                               64'(want.suffix_long_long));
            if (rsp_payload.suffix_size !== want.suffix_size)
               report_mismatch("suffix_size", 64'(rsp_payload.suffix_size),
                               64'(want.suffix_size));
            if (rsp_payload.parse_status !== want.parse_status)
               report_mismatch("parse_status", 64'(rsp_payload.parse_status),
                               64'(want.parse_status));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // bare zero, empty hex run, binary, decimal
   task automatic test_base_prefixes();
      send_token("0");
      send_token("0x");
      send_token("0b1");
      send_token("17");
   endtask

   // quote after octal zero, trailing quote, lone quote
   task automatic test_separators();
      send_token("0'7");
      send_token("1'");
      send_token("'");
   endtask

   // stray char, z after l, z with u, u with ll
   task automatic test_suffixes();
      send_token("7q");
      send_token("1lz");
      send_token("9Zu");
      send_token("1uLL");
   endtask

   // all-ones code point, well outside Unicode
   task automatic test_code_points();
      send_char(21'h1F_FFFF, 1'b1);
   endtask

   task automatic test_random_tokens(input int char_budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < char_budget) send_random_token();
   endtask

   // Results are held off for a long stretch while characters keep coming,
   // so the internal queue fills and req_stall has to rise.
   task automatic test_backpressure();
      long_hold_armed = 1'b1;
      repeat (24) send_random_token();
   endtask

   // No gaps and no stalls at all: back-to-back transactions on both sides
   task automatic test_steady_stream();
      idle_enabled = 1'b0;
      test_random_tokens(400);
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_literals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   endtask

   initial begin
      clear_lexer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_base_prefixes();
      test_separators();
      test_suffixes();
      test_code_points();
      test_random_tokens(1000);
      test_backpressure();
      test_steady_stream();
      finish_run();
   end

endmodule

[filelist.f]
sv/ilp_pkg.sv
sv/ilp_front.sv
sv/ilp_queue.sv
sv/ilp_exec.sv
sv/integer_literal_parser_core.sv
verif/tb_integer_literal_parser_core.sv
